### rtl/rrle_pkg.sv
`timescale 1ns / 1ps

package rrle_pkg;

    // Default depth of the job queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Pixels per run before a run is closed.
    localparam logic [7:0] RUN_MAX = 8'd128;

    // Header byte positions.
    localparam logic [5:0] HDR_FILE_START = 6'd0;
    localparam logic [5:0] HDR_PAGE_START = 6'd12;
    localparam logic [5:0] HDR_LAST       = 6'd43;

    // Pixel job steps: the row open byte, then run A, then run B.
    localparam logic [5:0] PIX_OPEN    = 6'd0;
    localparam logic [5:0] PIX_A_FIRST = 6'd1;
    localparam logic [5:0] PIX_A_LAST  = 6'd4;
    localparam logic [5:0] PIX_B_FIRST = 6'd5;
    localparam logic [5:0] PIX_B_LAST  = 6'd8;

    localparam logic [31:0] DPI_DEFAULT     = 32'd300;
    localparam logic [31:0] PAGES_SIMPLEX   = 32'd1;
    localparam logic [31:0] PAGES_DUPLEX    = 32'hFFFF_FFFF;
    localparam logic [7:0]  BITS_PER_PIXEL  = 8'd24;
    localparam logic [7:0]  COLORSPACE_SRGB = 8'd1;
    localparam logic [7:0]  MODE_SIMPLEX    = 8'd1;
    localparam logic [7:0]  MODE_TUMBLE     = 8'd2;
    localparam logic [7:0]  MODE_LONG_EDGE  = 8'd3;

    typedef enum logic [2:0] {
        CFG_ROW_WIDTH        = 3'd0,
        CFG_PAGE_HEIGHT      = 3'd1,
        CFG_RESOLUTION_DPI   = 3'd2,
        CFG_EMIT_FILE_HEADER = 3'd3,
        CFG_DUPLEX_MODE      = 3'd4,
        CFG_TUMBLE_MODE      = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] row_width;
        logic [15:0] page_height;
        logic [31:0] resolution_dpi;
        logic        emit_file_header;
        logic        duplex_mode;
        logic        tumble_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_HEADER = 2'd0,
        JOB_REJECT = 2'd1,
        JOB_PIXEL  = 2'd2
    } job_op_t;

    typedef struct packed {
        logic [7:0]  count;
        logic [23:0] colour;
    } run_t;

    typedef struct packed {
        job_op_t op;
        logic    row_open;
        logic    run_a_en;
        logic    run_b_en;
        run_t    run_a;
        run_t    run_b;
        logic    complete;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic {
        BK_START = 1'b0,
        BK_BUSY  = 1'b1
    } back_state_t;

    // One byte of the file and page header, by position in the 44-byte header.
    function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input cfg_t cfg);
        logic [31:0] pages;
        logic [31:0] dpi;
        logic [7:0]  mode;
        logic [7:0]  b;
        pages = cfg.duplex_mode ? PAGES_DUPLEX : PAGES_SIMPLEX;
        dpi   = (cfg.resolution_dpi == 32'd0) ? DPI_DEFAULT : cfg.resolution_dpi;
        mode  = cfg.duplex_mode ? (cfg.tumble_mode ? MODE_TUMBLE : MODE_LONG_EDGE)
                                : MODE_SIMPLEX;
        case (idx) inside
            6'd0:  b = 8'h55;
            6'd1:  b = 8'h4E;
            6'd2:  b = 8'h49;
            6'd3:  b = 8'h52;
            6'd4:  b = 8'h41;
            6'd5:  b = 8'h53;
            6'd6:  b = 8'h54;
            6'd8:  b = pages[31:24];
            6'd9:  b = pages[23:16];
            6'd10: b = pages[15:8];
            6'd11: b = pages[7:0];
            6'd12: b = BITS_PER_PIXEL;
            6'd13: b = COLORSPACE_SRGB;
            6'd14: b = mode;
            6'd26: b = cfg.row_width[15:8];
            6'd27: b = cfg.row_width[7:0];
            6'd30: b = cfg.page_height[15:8];
            6'd31: b = cfg.page_height[7:0];
            6'd32: b = dpi[31:24];
            6'd33: b = dpi[23:16];
            6'd34: b = dpi[15:8];
            6'd35: b = dpi[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // One byte of a pixel job, by step.
    function automatic logic [7:0] pix_byte(input logic [5:0] step, input job_t job);
        run_t       run;
        logic [7:0] b;
        run = (step >= PIX_B_FIRST) ? job.run_b : job.run_a;
        case (step) inside
            6'd1, 6'd5: b = run.count;
            6'd2, 6'd6: b = run.colour[23:16];
            6'd3, 6'd7: b = run.colour[15:8];
            6'd4, 6'd8: b = run.colour[7:0];
            default:    b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

### rtl/rrle_fifo.sv
`timescale 1ns / 1ps

module rrle_fifo
    import rrle_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/rrle_front.sv
`timescale 1ns / 1ps

module rrle_front
    import rrle_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      accept,
    input  logic      command,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic      push,
    output job_t      job
);

    logic        page_open_reg, page_open_next;
    logic [15:0] column_count_reg, column_count_next;
    logic [15:0] row_count_reg, row_count_next;
    logic [7:0]  run_length_reg, run_length_next;
    logic [23:0] run_colour_reg, run_colour_next;

    logic [23:0] colour_in;
    logic [23:0] colour_new;
    logic [7:0]  length_new;
    logic [15:0] column_inc;

    assign colour_in  = {red, green, blue};
    assign column_inc = column_count_reg + 16'd1;

    always_comb begin
        page_open_next    = page_open_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        run_length_next   = run_length_reg;
        run_colour_next   = run_colour_reg;
        colour_new        = run_colour_reg;
        length_new        = run_length_reg;
        push              = 1'b0;
        job               = '0;
        job.op            = JOB_PIXEL;

        if (accept) begin
            if (command) begin
                job.op            = JOB_HEADER;
                job.complete      = (cfg.page_height == 16'd0);
                push              = 1'b1;
                page_open_next    = 1'b1;
                column_count_next = '0;
                row_count_next    = '0;
                run_length_next   = '0;
                run_colour_next   = '0;
            end else if (!page_open_reg || row_count_reg >= cfg.page_height) begin
                job.op       = JOB_REJECT;
                job.complete = page_open_reg;
                push         = 1'b1;
            end else begin
                if (column_count_reg == 16'd0) begin
                    job.row_open = 1'b1;
                    colour_new   = colour_in;
                    length_new   = 8'd1;
                end else if (colour_in == run_colour_reg && run_length_reg < RUN_MAX) begin
                    length_new = run_length_reg + 8'd1;
                end else begin
                    job.run_a_en = 1'b1;
                    job.run_a    = '{count: run_length_reg - 8'd1, colour: run_colour_reg};
                    colour_new   = colour_in;
                    length_new   = 8'd1;
                end
                column_count_next = column_inc;
                run_colour_next   = colour_new;
                run_length_next   = length_new;
                // The row closes on width reached, or on counter wrap.
                if (column_inc == 16'd0 || column_inc >= cfg.row_width) begin
                    job.run_b_en      = 1'b1;
                    job.run_b         = '{count: length_new - 8'd1, colour: colour_new};
                    column_count_next = '0;
                    run_length_next   = '0;
                    row_count_next    = row_count_reg + 16'd1;
                end
                job.complete = (row_count_next >= cfg.page_height);
                push         = job.row_open || job.run_a_en || job.run_b_en;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_open_reg    <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            run_length_reg   <= '0;
            run_colour_reg   <= '0;
        end else begin
            page_open_reg    <= page_open_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            run_length_reg   <= run_length_next;
            run_colour_reg   <= run_colour_next;
        end
    end

endmodule

### rtl/rrle_back.sv
`timescale 1ns / 1ps

module rrle_back
    import rrle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  job_t       head_job,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_last,
    output logic       m_status,
    output logic       m_page_complete
);

    back_state_t state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_byte_reg;
    logic        m_last_reg, m_status_reg, m_page_complete_reg;

    logic        emit;
    logic [5:0]  start_step;
    logic [5:0]  cur_step;
    logic [5:0]  last_step;
    logic [5:0]  adv_step;
    logic [7:0]  cur_byte;
    logic        cur_last;

    assign emit = !q_status.empty && (!m_valid_reg || m_ready);
    assign pop  = emit && cur_last;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_START: if (emit && !cur_last) state_next = BK_BUSY;
            BK_BUSY:  if (emit && cur_last)  state_next = BK_START;
            default:  state_next = BK_START;
        endcase
    end

    // Byte selection and step sequencing for the job at the queue head.
    always_comb begin
        start_step = PIX_OPEN;
        last_step  = PIX_OPEN;
        adv_step   = '0;
        cur_byte   = 8'd0;
        unique case (head_job.op)
            JOB_HEADER: begin
                start_step = cfg.emit_file_header ? HDR_FILE_START : HDR_PAGE_START;
                last_step  = HDR_LAST;
            end
            JOB_PIXEL: begin
                start_step = head_job.row_open ? PIX_OPEN :
                             (head_job.run_a_en ? PIX_A_FIRST : PIX_B_FIRST);
                last_step  = head_job.run_b_en ? PIX_B_LAST :
                             (head_job.run_a_en ? PIX_A_LAST : PIX_OPEN);
            end
            default: begin
                start_step = PIX_OPEN;
                last_step  = PIX_OPEN;
            end
        endcase

        cur_step = (state_reg == BK_BUSY) ? step_reg : start_step;
        cur_last = (cur_step == last_step);

        unique case (head_job.op)
            JOB_HEADER: begin
                cur_byte = hdr_byte(cur_step, cfg);
                adv_step = cur_step + 6'd1;
            end
            JOB_PIXEL: begin
                cur_byte = pix_byte(cur_step, head_job);
                adv_step = (cur_step == PIX_OPEN && !head_job.run_a_en) ? PIX_B_FIRST
                                                                        : cur_step + 6'd1;
            end
            default: begin
                cur_byte = 8'd0;
                adv_step = cur_step;
            end
        endcase

        step_next    = emit ? adv_step : step_reg;
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_START;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_byte_reg     <= cur_byte;
            m_last_reg          <= cur_last;
            m_status_reg        <= (head_job.op == JOB_REJECT);
            m_page_complete_reg <= head_job.complete;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data_byte     = m_data_byte_reg;
    assign m_last          = m_last_reg;
    assign m_status        = m_status_reg;
    assign m_page_complete = m_page_complete_reg;

endmodule

### rtl/raster_row_run_length_encoder.sv
`timescale 1ns / 1ps
// The first result byte of an item passes through the job queue and then the output register.
// Throughput: one input transfer per cycle while the job queue has room, and one result byte
// per cycle while the receiver is ready. An item has 1 to 8 bytes for a pixel, 32 or 44 for
// a start page. A pixel that only extends a run makes no bytes. The byte-wide output
// register sets the output rate. Reset is synchronous, active low: config returns to its
// defaults, the page closes and the job queue empties.

module raster_row_run_length_encoder
    import rrle_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    // Input channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,

    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_byte,
    output logic        m_last,
    output logic        m_status,
    output logic        m_page_complete
);

    // The front end tracks the page, row and run state and turns every input transfer
    // into at most one job: a header job, a reject job or a pixel job that carries the
    // row open flag and up to two closed runs. Pixels that only extend a run make no job.
    // The back end walks the job at the queue head into the output register one byte per cycle
    // while the receiver is ready, so the front keeps taking pixels while long headers drain.

    cfg_t      cfg_reg, cfg_next;
    job_t      front_job;
    job_t      head_job;
    logic      front_push;
    logic      back_pop;
    logic      s_accept;
    q_status_t q_status;

    assign s_ready  = !q_status.full;
    assign s_accept = s_valid && s_ready;

    // Configuration registers; indexes past the list are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROW_WIDTH:        cfg_next.row_width        = cfg_wdata[15:0];
                CFG_PAGE_HEIGHT:      cfg_next.page_height      = cfg_wdata[15:0];
                CFG_RESOLUTION_DPI:   cfg_next.resolution_dpi   = cfg_wdata;
                CFG_EMIT_FILE_HEADER: cfg_next.emit_file_header = cfg_wdata[0];
                CFG_DUPLEX_MODE:      cfg_next.duplex_mode      = cfg_wdata[0];
                CFG_TUMBLE_MODE:      cfg_next.tumble_mode      = cfg_wdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_width        <= 16'd1;
            cfg_reg.page_height      <= 16'd1;
            cfg_reg.resolution_dpi   <= DPI_DEFAULT;
            cfg_reg.emit_file_header <= 1'b1;
            cfg_reg.duplex_mode      <= 1'b0;
            cfg_reg.tumble_mode      <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rrle_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .accept  (s_accept),
        .command (s_command),
        .red     (s_red),
        .green   (s_green),
        .blue    (s_blue),
        .push    (front_push),
        .job     (front_job)
    );

    // A push only happens on an input transfer, which requires a free entry.
    rrle_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (front_push),
        .push_job (front_job),
        .pop      (back_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    rrle_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .head_job        (head_job),
        .q_status        (q_status),
        .pop             (back_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_byte     (m_data_byte),
        .m_last          (m_last),
        .m_status        (m_status),
        .m_page_complete (m_page_complete)
    );

    // A rejected pixel yields exactly one zero byte.
    a_reject_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_last && m_data_byte == 8'd0))
        else $error("reject result is not a single zero byte");

    // A start-page transfer always leaves a job queued behind it.
    a_header_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_command) |=> !q_status.empty)
        else $error("start page produced no queued job");

    // The back end only pops while it presents a new byte.
    a_pop_with_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        back_pop |=> (m_valid && m_last))
        else $error("job popped without its last byte");

endmodule

### tb/rrle_stream_checker.sv
`timescale 1ns / 1ps

module rrle_stream_checker
    import rrle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_data_byte,
    input  logic        m_last,
    input  logic        m_status,
    input  logic        m_page_complete,
    output int          byte_errors,
    output int          bytes_outstanding,
    output int          bytes_compared
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       status;
        logic       complete;
    } stream_byte_t;

    // Sync word of the file header, with its trailing zero byte.
    localparam logic [63:0] SYNC_WORD = {"UNIRAST", 8'h00};

    cfg_t         regs;
    logic         page_open;
    logic [15:0]  col_cnt;
    logic [15:0]  row_cnt;
    logic [7:0]   run_len;
    logic [23:0]  run_rgb;
    stream_byte_t expected_bytes[$];
    logic [7:0]   encoded[$];
    int           faults;
    int           compared;

    function automatic void put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) begin
            encoded.push_back(w[8*i +: 8]);
        end
    endfunction

    function automatic void put_run();
        encoded.push_back(run_len - 8'd1);
        encoded.push_back(run_rgb[23:16]);
        encoded.push_back(run_rgb[15:8]);
        encoded.push_back(run_rgb[7:0]);
    endfunction

    // Works out the bytes that one accepted item produces and queues them.
    function automatic void encode_item(input logic cmd, input logic [23:0] rgb);
        logic rejected;
        logic done;
        rejected = 1'b0;
        encoded.delete();
        if (cmd) begin
            if (regs.emit_file_header) begin
                put_word(SYNC_WORD[63:32]);
                put_word(SYNC_WORD[31:0]);
                put_word(regs.duplex_mode ? PAGES_DUPLEX : PAGES_SIMPLEX);
            end
            encoded.push_back(BITS_PER_PIXEL);
            encoded.push_back(COLORSPACE_SRGB);
            encoded.push_back(regs.duplex_mode ?
                              (regs.tumble_mode ? MODE_TUMBLE : MODE_LONG_EDGE) : MODE_SIMPLEX);
            repeat (9) encoded.push_back(8'h00);
            put_word({16'h0000, regs.row_width});
            put_word({16'h0000, regs.page_height});
            put_word((regs.resolution_dpi == 32'd0) ? DPI_DEFAULT : regs.resolution_dpi);
            put_word(32'd0);
            put_word(32'd0);
            page_open = 1'b1;
            col_cnt   = '0;
            row_cnt   = '0;
            run_len   = '0;
            run_rgb   = '0;
        end else if (!page_open || row_cnt >= regs.page_height) begin
            rejected = 1'b1;
            encoded.push_back(8'h00);
        end else begin
            if (col_cnt == 16'd0) begin
                encoded.push_back(8'h00);
                run_rgb = rgb;
                run_len = 8'd1;
            end else if (rgb == run_rgb && run_len < RUN_MAX) begin
                run_len = run_len + 8'd1;
            end else begin
                put_run();
                run_rgb = rgb;
                run_len = 8'd1;
            end
            col_cnt = col_cnt + 16'd1;
            // A zero row width makes every pixel close its row.
            if (col_cnt == 16'd0 || col_cnt >= regs.row_width) begin
                put_run();
                col_cnt = '0;
                run_len = '0;
                row_cnt = row_cnt + 16'd1;
            end
        end
        done = page_open && (row_cnt >= regs.page_height);
        foreach (encoded[k]) begin
            expected_bytes.push_back(stream_byte_t'{encoded[k], k == encoded.size() - 1,
                                                   rejected, done});
        end
    endfunction

    always @(posedge aclk) begin
        stream_byte_t got;
        stream_byte_t want;
        if (!aresetn) begin
            regs = cfg_t'{row_width: 16'd1, page_height: 16'd1, resolution_dpi: DPI_DEFAULT,
                          emit_file_header: 1'b1, duplex_mode: 1'b0, tumble_mode: 1'b0};
            page_open = 1'b0;
            col_cnt   = '0;
            row_cnt   = '0;
            run_len   = '0;
            run_rgb   = '0;
            expected_bytes.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ROW_WIDTH:        regs.row_width        = cfg_wdata[15:0];
                    CFG_PAGE_HEIGHT:      regs.page_height      = cfg_wdata[15:0];
                    CFG_RESOLUTION_DPI:   regs.resolution_dpi   = cfg_wdata;
                    CFG_EMIT_FILE_HEADER: regs.emit_file_header = cfg_wdata[0];
                    CFG_DUPLEX_MODE:      regs.duplex_mode      = cfg_wdata[0];
                    CFG_TUMBLE_MODE:      regs.tumble_mode      = cfg_wdata[0];
                    default: ;
                endcase
            end
            // Results leave only after their item has passed the job queue and the output register, so the
            // output side is checked before this edge's input transfer adds its expectations.
            if (m_valid && m_ready) begin
                got = stream_byte_t'{m_data_byte, m_last, m_status, m_page_complete};
                if (expected_bytes.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("[%0t] Unexpected result: byte %02h last %b status %b complete %b",
                                 $realtime, got.data, got.last, got.status, got.complete);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.data !== want.data || got.last !== want.last ||
                        got.status !== want.status || got.complete !== want.complete) begin
                        faults++;
                        // Fields are byte/last/status/complete.
                        if (faults <= 10)
                            $display("[%0t] Result %0d: expected %02h/%b/%b/%b, got %02h/%b/%b/%b",
                                     $realtime, compared,
                                     want.data, want.last, want.status, want.complete,
                                     got.data, got.last, got.status, got.complete);
                    end
                end
                compared++;
            end
            if (s_valid && s_ready)
                encode_item(s_command, {s_red, s_green, s_blue});
        end
        byte_errors       <= faults;
        bytes_outstanding <= expected_bytes.size();
        bytes_compared    <= compared;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import rrle_pkg::*;
();

    // The slowest legal run covers about 470 items, a few dozen of them page starts of up to 44
    // bytes, each byte waiting out a random stall, plus one long hold-off. The limit leaves
    // several times the length of that run.
    localparam int LIMIT_CYCLES  = 500_000;
    localparam int HOLD_CYCLES   = 400;
    // A pixel that makes no bytes only updates the front end's state, so a short pause after
    // the last byte is ample margin before the registers change.
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_PCT      = 29;
    localparam int RANDOM_ITEMS  = 450;

    localparam logic CMD_PIXEL      = 1'b0;
    localparam logic CMD_START_PAGE = 1'b1;

    // Register indexes past the end of the map; writes there must be ignored.
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic [2:0]  cfg_index       = '0;
    logic [31:0] cfg_wdata       = '0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_command       = 1'b0;
    logic [7:0]  s_red           = '0;
    logic [7:0]  s_green         = '0;
    logic [7:0]  s_blue          = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_data_byte;
    logic        m_last;
    logic        m_status;
    logic        m_page_complete;

    int byte_errors;
    int bytes_outstanding;
    int bytes_compared;

    // Stimulus bookkeeping. calm switches off idling on both sides; hold_req asks the
    // receiver for one long hold-off.
    logic        calm     = 1'b0;
    logic        hold_req = 1'b0;
    logic [23:0] last_rgb = '0;
    int          cycle_count   = 0;
    int          items_sent    = 0;
    int          pages_started = 0;
    int          settings_used = 0;

    raster_row_run_length_encoder u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_byte     (m_data_byte),
        .m_last          (m_last),
        .m_status        (m_status),
        .m_page_complete (m_page_complete)
    );

    rrle_stream_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_red             (s_red),
        .s_green           (s_green),
        .s_blue            (s_blue),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data_byte       (m_data_byte),
        .m_last            (m_last),
        .m_status          (m_status),
        .m_page_complete   (m_page_complete),
        .byte_errors       (byte_errors),
        .bytes_outstanding (bytes_outstanding),
        .bytes_compared    (bytes_compared)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Run timed out after %0d cycles with %0d bytes still expected",
                     cycle_count, bytes_outstanding);
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random back-pressure, none while calm, and one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering items meanwhile.
    initial begin
        int held;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
                hold_req = 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offers one item and returns at the edge of its transfer, after any random gap.
    task automatic send_item(input logic cmd, input logic [23:0] rgb);
        s_valid   <= 1'b1;
        s_command <= cmd;
        {s_red, s_green, s_blue} <= rgb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (cmd) pages_started++;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    // Stops offering items, lets the checker book the last transfer, then waits until
    // every expected byte has arrived and any silent work has drained.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bytes_outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Programs the full register set once the block is idle. With junk set, the unused
    // upper bits of the narrow registers carry random values and the spare indexes are
    // written as well; both must have no effect.
    task automatic program_regs(input cfg_t c, input bit junk);
        logic [31:0] noise;
        noise = junk ? $urandom : 32'd0;
        settle();
        write_reg(CFG_ROW_WIDTH,        {noise[31:16], c.row_width});
        write_reg(CFG_PAGE_HEIGHT,      {noise[15:0], c.page_height});
        write_reg(CFG_RESOLUTION_DPI,   c.resolution_dpi);
        write_reg(CFG_EMIT_FILE_HEADER, {noise[31:1], c.emit_file_header});
        write_reg(CFG_DUPLEX_MODE,      {noise[30:0], c.duplex_mode});
        write_reg(CFG_TUMBLE_MODE,      {noise[29:0], noise[31], c.tumble_mode});
        if (junk) begin
            write_reg(CFG_SPARE_A, $urandom);
            write_reg(CFG_SPARE_B, $urandom);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Pixel colours mostly repeat, so that runs form, with extremes and random jumps.
    function automatic logic [23:0] next_rgb();
        int pick;
        pick = $urandom_range(99);
        if (pick >= 55 && pick < 65)
            last_rgb = ($urandom_range(1) != 0) ? 24'hFF_FFFF : 24'h00_0000;
        else if (pick >= 65)
            last_rgb = 24'($urandom);
        return last_rgb;
    endfunction

    function automatic cfg_t random_regs();
        cfg_t c;
        c.row_width   = ($urandom_range(99) < 85) ? 16'($urandom_range(1, 8))
                                                  : 16'($urandom_range(9, 40));
        c.page_height = ($urandom_range(99) < 5) ? 16'd0 : 16'($urandom_range(1, 4));
        case ($urandom_range(2))
            0:       c.resolution_dpi = 32'd0;
            1:       c.resolution_dpi = $urandom_range(72, 1200);
            default: c.resolution_dpi = $urandom;
        endcase
        c.emit_file_header = 1'($urandom_range(1));
        c.duplex_mode      = 1'($urandom_range(1));
        c.tumble_mode      = 1'($urandom_range(1));
        return c;
    endfunction

    initial begin
        cfg_t c;
        int   total;
        int   roll;
        int   page_idx;
        int   base_items;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        settle();

        // Directed part. Reset values first: a pixel with no page open is rejected, then
        // a one-pixel page with the file header, then a pixel on a full page.
        send_item(CMD_PIXEL, 24'hFF_FFFF);
        send_item(CMD_START_PAGE, 24'h00_0000);
        send_item(CMD_PIXEL, 24'hFF_FFFF);
        send_item(CMD_PIXEL, 24'h00_0000);

        // Page header only, duplex with tumble, dpi zero; a row with a run of two and a
        // run of one, then a new page in the middle of a row.
        program_regs(cfg_t'{row_width: 16'd3, page_height: 16'd2, resolution_dpi: 32'd0,
                            emit_file_header: 1'b0, duplex_mode: 1'b1, tumble_mode: 1'b1}, 1);
        send_item(CMD_START_PAGE, 24'hFF_FFFF);
        send_item(CMD_PIXEL, 24'hA5_5A_C3);
        send_item(CMD_PIXEL, 24'hA5_5A_C3);
        send_item(CMD_PIXEL, 24'h5A_A5_3C);
        send_item(CMD_PIXEL, 24'h01_02_04);
        send_item(CMD_PIXEL, 24'h80_40_20);
        send_item(CMD_START_PAGE, 24'h00_0000);

        // Zero row width: every pixel closes a row. Maximum height and dpi, long-edge duplex.
        program_regs(cfg_t'{row_width: 16'd0, page_height: 16'hFFFF,
                            resolution_dpi: 32'hFFFF_FFFF, emit_file_header: 1'b1,
                            duplex_mode: 1'b1, tumble_mode: 1'b0}, 0);
        send_item(CMD_START_PAGE, 24'h12_34_56);
        send_item(CMD_PIXEL, 24'h12_34_56);
        send_item(CMD_PIXEL, 24'h65_43_21);

        // Zero page height: the page is complete at once and pixels are rejected.
        // Tumble without duplex must still give simplex mode.
        program_regs(cfg_t'{row_width: 16'hFFFF, page_height: 16'd0, resolution_dpi: 32'd300,
                            emit_file_header: 1'b0, duplex_mode: 1'b0, tumble_mode: 1'b1}, 0);
        send_item(CMD_START_PAGE, 24'h00_0000);
        send_item(CMD_PIXEL, 24'hFF_00_FF);

        program_regs(cfg_t'{row_width: 16'd2, page_height: 16'd1, resolution_dpi: 32'd600,
                            emit_file_header: 1'b0, duplex_mode: 1'b0, tumble_mode: 1'b0}, 1);
        send_item(CMD_START_PAGE, 24'h00_0000);
        send_item(CMD_PIXEL, 24'h80_80_80);
        send_item(CMD_PIXEL, 24'h80_80_80);

        // Random part: mostly complete pages with random content. Some pages are cut short
        // or overrun, and now and then a page start lands in the middle of a page. Page 2
        // carries the long receiver hold-off and always sends its full 24 pixels so the
        // queue fills, page 4 is one wide row whose first 130 pixels fill a run to its
        // limit, and pages 10 to 17 run with no idling at all.
        base_items = items_sent;
        page_idx   = 0;
        while (items_sent - base_items < RANDOM_ITEMS) begin
            c = random_regs();
            if (page_idx == 2) begin
                c.row_width   = 16'd6;
                c.page_height = 16'd4;
            end
            if (page_idx == 4) begin
                c.row_width   = 16'd140;
                c.page_height = 16'd1;
            end
            calm = (page_idx >= 10 && page_idx < 18);
            program_regs(c, $urandom_range(3) == 0);
            send_item(CMD_START_PAGE, 24'($urandom));
            if (page_idx == 2) hold_req = 1'b1;

            total = c.row_width * c.page_height;
            roll  = $urandom_range(99);
            if (page_idx == 2) roll = 99;
            if (roll < 12 && total > 1)
                total = $urandom_range(1, total - 1);
            else if (roll < 27)
                total = total + $urandom_range(1, 3);

            for (int i = 0; i < total; i++) begin
                if (page_idx == 4 && i < 130)
                    send_item(CMD_PIXEL, 24'h3C_96_E1);
                else if ($urandom_range(99) < 2)
                    send_item(CMD_START_PAGE, 24'($urandom));
                else
                    send_item(CMD_PIXEL, next_rgb());
            end
            page_idx++;
        end
        calm = 1'b0;
        settle();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d items (%0d page starts) over %0d register settings,",
                 items_sent, pages_started, settings_used);
        $display("with %0d result bytes compared, %0d in error, %0d never delivered.",
                 bytes_compared, byte_errors, bytes_outstanding);
        if (byte_errors == 0 && bytes_outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/rrle_pkg.sv
rtl/rrle_fifo.sv
rtl/rrle_front.sv
rtl/rrle_back.sv
rtl/raster_row_run_length_encoder.sv
tb/rrle_stream_checker.sv
tb/tb_top.sv
